// File: hw/rtl/gbnms_pkg.sv
`default_nettype none

package gbnms_pkg;

  // Store geometry.
  localparam int MAX_KEPT = 256;
  localparam int ADDR_W   = $clog2(MAX_KEPT);
  localparam int CNT_W    = $clog2(MAX_KEPT + 1);

  // Field widths.
  localparam int COORD_W = 16;
  localparam int IDX_W   = 8;
  localparam int THR_W   = 16;

  localparam logic [THR_W-1:0] THR_RESET = 16'd19661;

  // Arithmetic widths: a signed edge span, a product of two spans, a union of
  // three such terms and the threshold product.
  localparam int DIFF_W     = COORD_W + 1;
  localparam int AREA_W     = 2 * DIFF_W;
  localparam int UNION_W    = AREA_W + 2;
  localparam int PROD_W     = UNION_W + THR_W + 1;
  localparam int FRAC_SHIFT = THR_W;

  typedef struct packed {
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_max;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // One comparison result leaving the IoU pipeline.
  typedef struct packed {
    logic vld;
    logic hit;
  } iou_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Signed extent hi - lo of one box edge pair.
  function automatic logic signed [DIFF_W-1:0] edge_span(input logic [COORD_W-1:0] lo,
                                                         input logic [COORD_W-1:0] hi);
    return $signed({1'b0, hi}) - $signed({1'b0, lo});
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gbnms_in_if.sv
`default_nettype none

interface gbnms_in_if;
  import gbnms_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_min;
  logic [COORD_W-1:0] y_min;
  logic [COORD_W-1:0] x_max;
  logic [COORD_W-1:0] y_max;
  logic [IDX_W-1:0]   box_index;
  logic               last_box;

  modport source (
    output valid, x_min, y_min, x_max, y_max, box_index, last_box,
    input  ready
  );

  modport sink (
    input  valid, x_min, y_min, x_max, y_max, box_index, last_box,
    output ready
  );

endinterface

`default_nettype wire

// File: hw/rtl/gbnms_out_if.sv
`default_nettype none

interface gbnms_out_if;
  import gbnms_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic             keep;
  logic             store_full;

  modport source (
    output valid, result_index, keep, store_full,
    input  ready
  );

  modport sink (
    input  valid, result_index, keep, store_full,
    output ready
  );

endinterface

`default_nettype wire

// File: hw/rtl/gbnms_ram.sv
`default_nettype none

module gbnms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/gbnms_iou.sv
`default_nettype none

module gbnms_iou (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  flush,
  input  wire logic                                  in_vld,
  input  wire gbnms_pkg::box_t                       kept,
  input  wire gbnms_pkg::box_t                       cand,
  input  wire logic signed [gbnms_pkg::AREA_W-1:0]   area_cand,
  input  wire logic        [gbnms_pkg::THR_W-1:0]    thr,
  output gbnms_pkg::iou_res_t                        res
);
  import gbnms_pkg::*;

  // Overlap of two intervals along one axis, ordered by their lower edge.
  function automatic logic signed [DIFF_W-1:0] axis_ovl(input logic [COORD_W-1:0] amin,
                                                        input logic [COORD_W-1:0] amax,
                                                        input logic [COORD_W-1:0] bmin,
                                                        input logic [COORD_W-1:0] bmax);
    logic [COORD_W-1:0] lo_max;
    logic [COORD_W-1:0] hi_min;
    logic [COORD_W-1:0] hi_max;
    logic [COORD_W-1:0] top;
    if (amin > bmin) begin
      lo_max = bmax;
      hi_min = amin;
      hi_max = amax;
    end else begin
      lo_max = amax;
      hi_min = bmin;
      hi_max = bmax;
    end
    top = (lo_max < hi_max) ? lo_max : hi_max;
    if (lo_max < hi_min) begin
      return '0;
    end
    return $signed({1'b0, top}) - $signed({1'b0, hi_min});
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic signed [DIFF_W-1:0]  ox_r, oy_r, dxk_r, dyk_r;
  logic signed [AREA_W-1:0]  ov2_r, ak2_r;
  logic signed [UNION_W-1:0] un3_r;
  logic signed [AREA_W-1:0]  ov3_r, ov4_r;
  logic signed [PROD_W-1:0]  prod4_r;
  logic                      nz4_r;
  logic                      hit5_r;

  logic signed [THR_W:0]   thr_s;
  logic signed [PROD_W-1:0] lhs;

  assign thr_s = $signed({1'b0, thr});
  assign lhs   = PROD_W'(ov4_r) <<< FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_vld && !flush;
      v2_r <= v1_r && !flush;
      v3_r <= v2_r && !flush;
      v4_r <= v3_r && !flush;
      v5_r <= v4_r && !flush;
    end
  end

  always_ff @(posedge clk) begin
    // Axis overlaps and the kept box's spans.
    ox_r  <= axis_ovl(cand.x_min, cand.x_max, kept.x_min, kept.x_max);
    oy_r  <= axis_ovl(cand.y_min, cand.y_max, kept.y_min, kept.y_max);
    dxk_r <= edge_span(kept.x_min, kept.x_max);
    dyk_r <= edge_span(kept.y_min, kept.y_max);
    // Overlap area and kept area.
    ov2_r <= ox_r * oy_r;
    ak2_r <= dxk_r * dyk_r;
    // Union.
    un3_r <= UNION_W'(area_cand) + UNION_W'(ak2_r) - UNION_W'(ov2_r);
    ov3_r <= ov2_r;
    // Threshold times union.
    prod4_r <= thr_s * un3_r;
    ov4_r   <= ov3_r;
    nz4_r   <= (un3_r != '0);
    // Final compare; a zero union never suppresses.
    hit5_r <= nz4_r && (lhs > prod4_r);
  end

  assign res.vld = v5_r;
  assign res.hit = hit5_r;

endmodule

`default_nettype wire

// File: hw/rtl/greedy_box_nms.sv
// Greedy non-maximum suppression over boxes that arrive in descending score
// order. Each input beat carries one box; the block compares it against the
// boxes kept so far, in store order, and returns exactly one result beat that
// says whether the box was kept, suppressed, or survived while the store was
// full. A box is suppressed by the first kept box for which
// overlap * 65536 > iou_threshold * union; a zero union never suppresses.
// Kept boxes live in a single-port-write, registered-read RAM of MAX_KEPT
// entries, read one entry per cycle by a five-stage IoU pipeline. One box is
// worked on at a time; with an empty store the scan is skipped. A suppressing
// hit ends the scan once its result leaves the pipeline, and comparisons still
// in flight are dropped. A box flagged last_box is judged first, then the
// store is emptied. The store needs no clearing pass after reset; only entries
// below the kept count are ever read. The threshold, written through cfg_we
// and cfg_wdata, resets to about 0.3; the user must write it only while the
// block is idle, which the block itself does not enforce.
`default_nettype none

module greedy_box_nms (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  gbnms_in_if.sink                           in_ch,
  gbnms_out_if.source                        out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [gbnms_pkg::THR_W-1:0]   cfg_wdata
);
  import gbnms_pkg::*;

  state_t state_r, state_nxt;

  box_t                     cand_r;
  logic [IDX_W-1:0]         idx_r;
  logic                     last_r;
  logic signed [AREA_W-1:0] area_r;
  logic [CNT_W-1:0]         iss_r;
  logic [CNT_W-1:0]         res_r;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic                     supp_r, supp_nxt;
  logic                     rd_vld_r;
  logic [THR_W-1:0]         thr_r;

  logic             out_vld_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_keep_r;
  logic             out_full_r;

  logic             in_fire;
  logic             out_free;
  logic             store_room;
  logic             rd_en;
  logic             flush;
  logic             finish_fire;
  logic             verdict_keep;
  logic             ram_we;
  logic [BOX_W-1:0] ram_rdata;
  iou_res_t         iou_res;

  // No beat is taken while reset is held.
  assign in_ch.ready  = rst_n && (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_vld_r || out_ch.ready;
  assign store_room   = (count_r < CNT_W'(MAX_KEPT));
  assign rd_en        = (state_r == ST_SCAN) && (iss_r < count_r);
  assign verdict_keep = !supp_r && store_room;
  assign finish_fire  = (state_r == ST_FINISH) && out_free;
  assign ram_we       = finish_fire && verdict_keep;

  // The kept count moves only when a verdict is delivered: a stored box
  // appends, and the last box of a set empties the store afterward.
  always_comb begin
    count_nxt = count_r;
    if (finish_fire) begin
      if (last_r) begin
        count_nxt = '0;
      end else if (verdict_keep) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer. The scan issues one RAM read per cycle and ends at the first
  // hit, or once every kept box has come back from the pipeline clean.
  always_comb begin
    state_nxt = state_r;
    supp_nxt  = supp_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        supp_nxt = 1'b0;
        if (count_r == '0) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (iou_res.vld) begin
          if (iou_res.hit) begin
            supp_nxt  = 1'b1;
            state_nxt = ST_FINISH;
          end else if (res_r + CNT_W'(1) == count_r) begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Leaving the scan drops every comparison still in flight.
  assign flush = (state_r == ST_SCAN) && (state_nxt != ST_SCAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      thr_r     <= THR_RESET;
      out_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
      supp_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      supp_r   <= supp_nxt;
      rd_vld_r <= rd_en && !flush;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (finish_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cand_r.x_min <= in_ch.x_min;
      cand_r.y_min <= in_ch.y_min;
      cand_r.x_max <= in_ch.x_max;
      cand_r.y_max <= in_ch.y_max;
      idx_r        <= in_ch.box_index;
      last_r       <= in_ch.last_box;
    end
    if (state_r == ST_PREP) begin
      area_r <= edge_span(cand_r.x_min, cand_r.x_max) * edge_span(cand_r.y_min, cand_r.y_max);
      iss_r  <= '0;
      res_r  <= '0;
    end else begin
      if (rd_en) begin
        iss_r <= iss_r + CNT_W'(1);
      end
      if ((state_r == ST_SCAN) && iou_res.vld) begin
        res_r <= res_r + CNT_W'(1);
      end
    end
    if (finish_fire) begin
      out_idx_r  <= idx_r;
      out_keep_r <= verdict_keep;
      out_full_r <= !supp_r && !store_room;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_index = out_idx_r;
  assign out_ch.keep         = out_keep_r;
  assign out_ch.store_full   = out_full_r;

  gbnms_ram #(
    .WIDTH (BOX_W),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (cand_r),
    .re    (rd_en),
    .raddr (iss_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  gbnms_iou u_iou (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (flush),
    .in_vld    (rd_vld_r),
    .kept      (box_t'(ram_rdata)),
    .cand      (cand_r),
    .area_cand (area_r),
    .thr       (thr_r),
    .res       (iou_res)
  );

`ifndef SYNTHESIS
  // The store never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_KEPT))
    else $error("kept count beyond store capacity");

  // A store write happens only when a verdict leaves and there is room.
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_FINISH) && store_room)
    else $error("store written without room or outside a verdict");

  // A result is never both kept and reported as overflowing the store.
  a_out_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_keep_r && out_full_r))
    else $error("keep and store_full both set");

  // During the scan no more reads are issued or results seen than kept boxes.
  a_scan_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_r <= count_r) && (res_r < count_r))
    else $error("scan counters out of range");

  // After a flush no stale comparison comes out of the pipeline.
  a_flush_clean: assert property (@(posedge clk) disable iff (!rst_n)
    flush |=> !iou_res.vld)
    else $error("comparison result after flush");
`endif

endmodule

`default_nettype wire
